// File: sv/mbt_pkg.sv
package mbt_pkg;

  // Default table depth
  localparam int DEPTH_DEF = 64;

  // Field widths
  localparam int CMD_W       = 2;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 6;
  localparam int CNT_OUT_W   = 7;
  localparam int OUT_TDATA_W = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  // One-hot decoded operation
  typedef struct packed {
    logic ins;
    logic del;
    logic qry;
    logic clr;
  } ops_t;

  // Classified item handed to the back end
  typedef struct packed {
    ops_t              ops;
    logic [DATA_W-1:0] value;
  } job_t;

  // Result item
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] count;
    logic                 bag_empty;
  } result_t;

endpackage

// File: sv/mbt_front.sv
module mbt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mbt_pkg::DATA_W-1:0]    in_tdata,   // [31:0] item_value
  input  logic [mbt_pkg::CMD_W-1:0]     in_tuser,   // [1:0] command
  output logic                          job_valid,
  input  logic                          job_ready,
  output mbt_pkg::job_t                 job
);

  logic          hold_valid_r, hold_valid_nxt;
  mbt_pkg::job_t job_r, job_nxt;
  mbt_pkg::ops_t ops_dec;
  logic          load;

  // Decode the command into a one-hot operation
  always_comb begin
    ops_dec = '0;
    unique case (in_tuser)
      mbt_pkg::CMD_INSERT: ops_dec.ins = 1'b1;
      mbt_pkg::CMD_DELETE: ops_dec.del = 1'b1;
      mbt_pkg::CMD_QUERY:  ops_dec.qry = 1'b1;
      mbt_pkg::CMD_CLEAR:  ops_dec.clr = 1'b1;
      default:             ops_dec     = '0;
    endcase
  end

  // Single holding register, refilled as soon as it drains
  assign in_tready = !hold_valid_r || job_ready;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    job_nxt        = job_r;
    if (load) begin
      hold_valid_nxt = 1'b1;
      job_nxt.ops    = ops_dec;
      job_nxt.value  = in_tdata;
    end else if (job_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    job_r <= job_nxt;
  end

  assign job_valid = hold_valid_r;
  assign job       = job_r;

endmodule

// File: sv/mbt_queue.sv
module mbt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  mbt_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mbt_pkg::job_t pop_job
);

  mbt_pkg::job_t                slots_r [mbt_pkg::QUEUE_DEPTH];
  logic [mbt_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mbt_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mbt_pkg::QFILL_W-1:0]  fill_r, fill_nxt;
  logic                         push, pop;

  localparam logic [mbt_pkg::QPTR_W-1:0] PTR_LAST = mbt_pkg::QPTR_W'(mbt_pkg::QUEUE_DEPTH - 1);

  assign push_ready = fill_r != mbt_pkg::QFILL_W'(mbt_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: sv/mbt_back.sv
module mbt_back #(
  parameter int DEPTH = mbt_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  mbt_pkg::job_t    job,
  output logic             out_valid,
  input  logic             out_ready,
  output mbt_pkg::result_t out_res
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IDXW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_RDLAST = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

  // Entry table, synchronous read
  logic [mbt_pkg::DATA_W-1:0] mem [DEPTH];
  logic [mbt_pkg::DATA_W-1:0] rd_data_r;

  logic [2:0]                   state_r, state_nxt;
  logic [CNTW-1:0]              count_r, count_nxt;
  logic [CNTW-1:0]              scan_r, scan_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic [IDXW-1:0]              idx_pend_r, idx_pend_nxt;
  mbt_pkg::ops_t                ops_r, ops_nxt;
  logic [mbt_pkg::DATA_W-1:0]   value_r, value_nxt;
  logic                         hit_r, hit_nxt;
  logic [IDXW-1:0]              slot_r, slot_nxt;
  logic [mbt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mbt_pkg::result_t             out_res_r, out_res_nxt;

  logic                         mem_re, mem_we;
  logic [IDXW-1:0]              rd_addr, wr_addr;
  logic [mbt_pkg::DATA_W-1:0]   wr_data;
  logic                         match, exhausted, load_out;
  logic [CNTW-1:0]              last_cnt;
  logic [IDXW+mbt_pkg::POS_W-1:0]     pos_ext;
  logic [CNTW+mbt_pkg::CNT_OUT_W-1:0] cnt_ext;

  assign job_ready = (state_r == S_IDLE);
  assign match     = rd_pend_r && (rd_data_r == value_r);
  assign exhausted = !rd_pend_r && (scan_r >= count_r);
  assign last_cnt  = count_r - 1'b1;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign pos_ext   = {{mbt_pkg::POS_W{1'b0}}, slot_r};
  assign cnt_ext   = {{mbt_pkg::CNT_OUT_W{1'b0}}, count_r};

  // Sequencer: search, resolve, optional move of the last entry
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    rd_pend_nxt  = rd_pend_r;
    idx_pend_nxt = idx_pend_r;
    ops_nxt      = ops_r;
    value_nxt    = value_r;
    hit_nxt      = hit_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    rd_addr      = '0;
    wr_addr      = '0;
    wr_data      = value_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          ops_nxt     = job.ops;
          value_nxt   = job.value;
          scan_nxt    = '0;
          rd_pend_nxt = 1'b0;
          hit_nxt     = 1'b0;
          slot_nxt    = '0;
          status_nxt  = mbt_pkg::ST_DONE;
          state_nxt   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (match || exhausted) begin
          hit_nxt     = match;
          slot_nxt    = match ? idx_pend_r : '0;
          rd_pend_nxt = 1'b0;
          state_nxt   = S_DONE;
          status_nxt  = mbt_pkg::ST_DONE;
          priority if (ops_r.ins) begin
            if (count_r < CNT_FULL) begin
              mem_we    = 1'b1;
              wr_addr   = count_r[IDXW-1:0];
              count_nxt = count_r + 1'b1;
            end else begin
              status_nxt = mbt_pkg::ST_FULL;
            end
          end else if (ops_r.del) begin
            if (match) begin
              state_nxt = S_RDLAST;
            end else begin
              status_nxt = mbt_pkg::ST_MISSING;
            end
          end else if (ops_r.qry) begin
            if (!match) begin
              status_nxt = mbt_pkg::ST_MISSING;
            end
          end else begin
            count_nxt = '0;
          end
        end else if (scan_r < count_r) begin
          // keep one read in flight while comparing the previous one
          mem_re       = 1'b1;
          rd_addr      = scan_r[IDXW-1:0];
          rd_pend_nxt  = 1'b1;
          idx_pend_nxt = scan_r[IDXW-1:0];
          scan_nxt     = scan_r + 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
        end
      end
      S_RDLAST: begin
        mem_re    = 1'b1;
        rd_addr   = last_cnt[IDXW-1:0];
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        wr_addr   = slot_r;
        wr_data   = rd_data_r;
        count_nxt = last_cnt;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt         = 1'b1;
      out_res_nxt.status    = status_r;
      out_res_nxt.found     = hit_r;
      out_res_nxt.position  = pos_ext[mbt_pkg::POS_W-1:0];
      out_res_nxt.count     = cnt_ext[mbt_pkg::CNT_OUT_W-1:0];
      out_res_nxt.bag_empty = (count_r == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r     <= scan_nxt;
    idx_pend_r <= idx_pend_nxt;
    ops_r      <= ops_nxt;
    value_r    <= value_nxt;
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    out_res_r  <= out_res_nxt;
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count beyond depth");

  // Every read under comparison targets a live entry
  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) && rd_pend_r |-> CNTW'(idx_pend_r) < count_r)
    else $error("search compared an entry past the count");

  // A move always shrinks the bag by exactly one
  a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |=> (CNTW'(count_r + 1'b1) == $past(count_r)))
    else $error("delete move did not shrink count by one");

  // Move only follows a hit
  a_move_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDLAST) |-> hit_r && ops_r.del)
    else $error("last-entry fetch without a delete hit");

endmodule

// File: sv/multiset_bag_table_core.sv
// Operation: the search reads the live entries one entry per cycle until a match or the
// end of the bag; a delete that hits then fetches the last entry and moves it into the
// freed slot.
// Back end: it takes a new item only once the result of the last one is in the output
// register, so items do not overlap; the queue holds up to two items meanwhile.
// Reset (rst_n low, synchronous): bag empty, both channels idle; table contents kept.
module multiset_bag_table_core #(
  parameter int DEPTH = mbt_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mbt_pkg::DATA_W-1:0]      in_tdata,   // [31:0] item_value
  input  logic [mbt_pkg::CMD_W-1:0]       in_tuser,   // [1:0] command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mbt_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] found, [6:1] position,
                                                      // [13:7] count, [14] bag_empty, [15] 0
  output logic [mbt_pkg::STATUS_W-1:0]    out_tuser   // [1:0] status
);

  logic             fr_valid, fr_ready;
  mbt_pkg::job_t    fr_job;
  logic             q_valid, q_ready;
  mbt_pkg::job_t    q_job;
  mbt_pkg::result_t res;

  // Accept and classify
  mbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  // Decoupling queue
  mbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_job   (fr_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  // Search and update engine
  mbt_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Result packing
  assign out_tuser = res.status;
  assign out_tdata = {1'b0, res.bag_empty, res.count, res.position, res.found};

endmodule
